[hdl/mbe_pkg.sv]
`default_nettype none

package mbe_pkg;

   localparam int PIXEL_BITS   = 12;
   localparam int ITER_BITS    = 16;
   localparam int DATA_BITS    = 64;
   localparam int STEP_BITS    = 63;
   localparam int FRAC_BITS    = 52;
   localparam int HALF_BITS    = DATA_BITS / 2;
   localparam int PROD_BITS    = 2 * DATA_BITS;
   localparam int CSR_IDX_BITS = 3;
   localparam int MUL_STEPS    = 4;
   localparam int MUL_CNT_BITS = $clog2(MUL_STEPS + 1);
   localparam int BAILOUT      = 20;

   localparam logic [DATA_BITS-1:0] SAT_MAX    = {1'b0, {(DATA_BITS-1){1'b1}}};
   localparam logic [DATA_BITS-1:0] SAT_MIN    = {1'b1, {(DATA_BITS-1){1'b0}}};
   localparam logic [DATA_BITS-1:0] BAILOUT_SQ = DATA_BITS'(BAILOUT * BAILOUT) << FRAC_BITS;
   localparam logic [ITER_BITS-1:0] MAX_ITER_RESET = ITER_BITS'(256);

   typedef enum logic [CSR_IDX_BITS-1:0] {
      CSR_X_LEFT   = 3'd0,
      CSR_X_STEP   = 3'd1,
      CSR_Y_TOP    = 3'd2,
      CSR_Y_STEP   = 3'd3,
      CSR_MAX_ITER = 3'd4
   } csr_idx_type;

   typedef enum logic [2:0] {
      MSEL_MAP_X = 3'd0,
      MSEL_MAP_Y = 3'd1,
      MSEL_XX    = 3'd2,
      MSEL_YY    = 3'd3,
      MSEL_XY    = 3'd4
   } msel_type;

   typedef struct packed {
      logic     clear;
      logic     mul_start;
      msel_type mul_sel;
      logic     load_map_x;
      logic     load_map_y;
      logic     load_xx;
      logic     load_yy;
      logic     load_xy;
      logic     eval_bail;
      logic     eval_nx;
      logic     eval_dbl;
      logic     update;
      logic     out_load;
   } cmd_type;

   typedef struct packed {
      logic mul_done;
      logic limit_hit;
      logic esc_hit;
   } stat_type;

endpackage

`default_nettype wire

[hdl/mbe_ifs.sv]
`default_nettype none

interface mbe_req_if import mbe_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [PIXEL_BITS-1:0] pixel_x;
   logic [PIXEL_BITS-1:0] pixel_y;

   modport source (output valid, output pixel_x, output pixel_y, input ready);
   modport sink   (input valid, input pixel_x, input pixel_y, output ready);
endinterface

interface mbe_rsp_if import mbe_pkg::*; ();
   logic                        valid;
   logic                        ready;
   logic [ITER_BITS-1:0]        iter_count;
   logic                        escaped;
   logic signed [DATA_BITS-1:0] final_re;
   logic signed [DATA_BITS-1:0] final_im;

   modport source (output valid, output iter_count, output escaped, output final_re,
                   output final_im, input ready);
   modport sink   (input valid, input iter_count, input escaped, input final_re,
                   input final_im, output ready);
endinterface

interface mbe_csr_if import mbe_pkg::*; ();
   logic                    valid;
   logic                    ready;
   logic [CSR_IDX_BITS-1:0] index;
   logic [DATA_BITS-1:0]    data;

   modport source (output valid, output index, output data, input ready);
   modport sink   (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

[hdl/mbe_mul.sv]
`default_nettype none

module mbe_mul import mbe_pkg::*; (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [DATA_BITS-1:0] a,
   input  wire logic [DATA_BITS-1:0] b,
   output logic                      done,
   output logic [PROD_BITS-1:0]      product
);

   logic                    busy_ff, busy_in;
   logic                    done_ff, done_in;
   logic [MUL_CNT_BITS-1:0] cnt_ff, cnt_in;
   logic [DATA_BITS-1:0]    a_ff, a_in;
   logic [DATA_BITS-1:0]    b_ff, b_in;
   logic [DATA_BITS-1:0]    pp_ff, pp_in;
   logic [1:0]              sh_ff, sh_in;
   logic [PROD_BITS-1:0]    acc_ff, acc_in;
   logic [HALF_BITS-1:0]    a_half;
   logic [HALF_BITS-1:0]    b_half;
   logic [PROD_BITS-1:0]    pp_shifted;

   always_comb begin
      a_half     = cnt_ff[1] ? a_ff[DATA_BITS-1:HALF_BITS] : a_ff[HALF_BITS-1:0];
      b_half     = cnt_ff[0] ? b_ff[DATA_BITS-1:HALF_BITS] : b_ff[HALF_BITS-1:0];
      pp_shifted = {{(PROD_BITS-DATA_BITS){1'b0}}, pp_ff} << (32'(sh_ff) * HALF_BITS);

      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      a_in    = a_ff;
      b_in    = b_ff;
      pp_in   = {{HALF_BITS{1'b0}}, a_half} * {{HALF_BITS{1'b0}}, b_half};
      sh_in   = {cnt_ff[1] & cnt_ff[0], cnt_ff[1] ^ cnt_ff[0]};
      acc_in  = acc_ff;

      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         a_in    = a;
         b_in    = b;
         acc_in  = '0;
      end else if (busy_ff) begin
         cnt_in = cnt_ff + 1'b1;
         if (cnt_ff != '0) begin
            acc_in = acc_ff + pp_shifted;
         end
         if (cnt_ff == MUL_CNT_BITS'(MUL_STEPS)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff   <= a_in;
      b_ff   <= b_in;
      pp_ff  <= pp_in;
      sh_ff  <= sh_in;
      acc_ff <= acc_in;
   end

   assign done    = done_ff;
   assign product = acc_ff;

endmodule

`default_nettype wire

[hdl/mbe_ctrl.sv]
`default_nettype none

module mbe_ctrl import mbe_pkg::*; (
   input  wire logic     clock,
   input  wire logic     reset,
   input  wire logic     req_valid,
   output logic          req_ready,
   output logic          rsp_valid,
   input  wire logic     rsp_ready,
   input  wire stat_type stat,
   output cmd_type       cmd
);

   typedef enum logic [12:0] {
      ST_IDLE    = 13'h0001,
      ST_MAP_X   = 13'h0002,
      ST_WAIT_MX = 13'h0004,
      ST_WAIT_MY = 13'h0008,
      ST_CHECK   = 13'h0010,
      ST_WAIT_XX = 13'h0020,
      ST_WAIT_YY = 13'h0040,
      ST_BAIL    = 13'h0080,
      ST_NEXT_RE = 13'h0100,
      ST_WAIT_XY = 13'h0200,
      ST_DOUBLE  = 13'h0400,
      ST_UPDATE  = 13'h0800,
      ST_FINISH  = 13'h1000
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      cmd.mul_sel = MSEL_MAP_X;
      req_ready = 1'b0;

      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               cmd.clear = 1'b1;
               state_in  = ST_MAP_X;
            end
         end
         ST_MAP_X: begin
            cmd.mul_start = 1'b1;
            cmd.mul_sel   = MSEL_MAP_X;
            state_in      = ST_WAIT_MX;
         end
         ST_WAIT_MX: begin
            if (stat.mul_done) begin
               cmd.load_map_x = 1'b1;
               cmd.mul_start  = 1'b1;
               cmd.mul_sel    = MSEL_MAP_Y;
               state_in       = ST_WAIT_MY;
            end
         end
         ST_WAIT_MY: begin
            if (stat.mul_done) begin
               cmd.load_map_y = 1'b1;
               state_in       = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (stat.limit_hit) begin
               state_in = ST_FINISH;
            end else begin
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = MSEL_XX;
               state_in      = ST_WAIT_XX;
            end
         end
         ST_WAIT_XX: begin
            if (stat.mul_done) begin
               cmd.load_xx   = 1'b1;
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = MSEL_YY;
               state_in      = ST_WAIT_YY;
            end
         end
         ST_WAIT_YY: begin
            if (stat.mul_done) begin
               cmd.load_yy   = 1'b1;
               cmd.mul_start = 1'b1;
               cmd.mul_sel   = MSEL_XY;
               state_in      = ST_BAIL;
            end
         end
         ST_BAIL: begin
            cmd.eval_bail = 1'b1;
            state_in      = ST_NEXT_RE;
         end
         ST_NEXT_RE: begin
            if (stat.esc_hit) begin
               state_in = ST_FINISH;
            end else begin
               cmd.eval_nx = 1'b1;
               state_in    = ST_WAIT_XY;
            end
         end
         ST_WAIT_XY: begin
            if (stat.mul_done) begin
               cmd.load_xy = 1'b1;
               state_in    = ST_DOUBLE;
            end
         end
         ST_DOUBLE: begin
            cmd.eval_dbl = 1'b1;
            state_in     = ST_UPDATE;
         end
         ST_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = ST_CHECK;
         end
         ST_FINISH: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      rsp_valid_in = cmd.out_load | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

`default_nettype wire

[hdl/mbe_dpath.sv]
`default_nettype none

module mbe_dpath import mbe_pkg::*; (
   input  wire logic                    clock,
   input  wire logic                    reset,
   input  wire cmd_type                 cmd,
   output stat_type                     stat,
   input  wire logic [PIXEL_BITS-1:0]   pixel_x,
   input  wire logic [PIXEL_BITS-1:0]   pixel_y,
   input  wire logic                    csr_valid,
   output logic                         csr_ready,
   input  wire logic [CSR_IDX_BITS-1:0] csr_index,
   input  wire logic [DATA_BITS-1:0]    csr_data,
   output logic [ITER_BITS-1:0]         iter_count,
   output logic                         escaped,
   output logic signed [DATA_BITS-1:0]  final_re,
   output logic signed [DATA_BITS-1:0]  final_im
);

   function automatic logic [DATA_BITS-1:0] sat_add(input logic [DATA_BITS-1:0] a,
                                                    input logic [DATA_BITS-1:0] b);
      logic [DATA_BITS-1:0] r;
      logic [DATA_BITS-1:0] ovf;
      r   = a + b;
      ovf = (a ^ r) & (b ^ r);
      if (ovf[DATA_BITS-1]) begin
         r = a[DATA_BITS-1] ? SAT_MIN : SAT_MAX;
      end
      return r;
   endfunction

   function automatic logic [DATA_BITS-1:0] sat_sub(input logic [DATA_BITS-1:0] a,
                                                    input logic [DATA_BITS-1:0] b);
      logic [DATA_BITS-1:0] r;
      logic [DATA_BITS-1:0] ovf;
      r   = a - b;
      ovf = (a ^ b) & (a ^ r);
      if (ovf[DATA_BITS-1]) begin
         r = a[DATA_BITS-1] ? SAT_MIN : SAT_MAX;
      end
      return r;
   endfunction

   function automatic logic [DATA_BITS-1:0] qfix(input logic [PROD_BITS-1:0] p,
                                                 input logic neg);
      logic                 ovf;
      logic [DATA_BITS-1:0] q;
      logic [DATA_BITS-1:0] r;
      ovf = |p[PROD_BITS-1:FRAC_BITS+DATA_BITS];
      q   = p[FRAC_BITS+DATA_BITS-1:FRAC_BITS];
      if (!neg) begin
         r = (ovf || q[DATA_BITS-1]) ? SAT_MAX : q;
      end else begin
         r = (ovf || q > SAT_MIN) ? SAT_MIN : (DATA_BITS'(0) - q);
      end
      return r;
   endfunction

   function automatic logic [DATA_BITS-1:0] map_up(input logic [DATA_BITS-1:0] base,
                                                   input logic [PROD_BITS-1:0] p);
      logic [DATA_BITS-1:0] biased;
      logic [DATA_BITS-1:0] lo;
      logic [DATA_BITS-1:0] r;
      biased = base ^ SAT_MIN;
      lo     = p[DATA_BITS-1:0];
      if ((|p[PROD_BITS-1:DATA_BITS]) || lo > ~biased) begin
         r = SAT_MAX;
      end else begin
         r = (biased + lo) ^ SAT_MIN;
      end
      return r;
   endfunction

   function automatic logic [DATA_BITS-1:0] map_down(input logic [DATA_BITS-1:0] base,
                                                     input logic [PROD_BITS-1:0] p);
      logic [DATA_BITS-1:0] biased;
      logic [DATA_BITS-1:0] lo;
      logic [DATA_BITS-1:0] r;
      biased = base ^ SAT_MIN;
      lo     = p[DATA_BITS-1:0];
      if ((|p[PROD_BITS-1:DATA_BITS]) || lo > biased) begin
         r = SAT_MIN;
      end else begin
         r = (biased - lo) ^ SAT_MIN;
      end
      return r;
   endfunction

   logic [DATA_BITS-1:0]  x_left_ff, x_left_in;
   logic [STEP_BITS-1:0]  x_step_ff, x_step_in;
   logic [DATA_BITS-1:0]  y_top_ff, y_top_in;
   logic [STEP_BITS-1:0]  y_step_ff, y_step_in;
   logic [ITER_BITS-1:0]  max_iter_ff, max_iter_in;
   logic [DATA_BITS-1:0]  z_re_ff, z_re_in;
   logic [DATA_BITS-1:0]  z_im_ff, z_im_in;
   logic [DATA_BITS-1:0]  c_re_ff, c_re_in;
   logic [DATA_BITS-1:0]  c_im_ff, c_im_in;
   logic [ITER_BITS-1:0]  n_ff, n_in;
   logic                  esc_ff, esc_in;
   logic [PIXEL_BITS-1:0] px_ff, px_in;
   logic [PIXEL_BITS-1:0] py_ff, py_in;
   logic [DATA_BITS-1:0]  xx_ff, xx_in;
   logic [DATA_BITS-1:0]  yy_ff, yy_in;
   logic [DATA_BITS-1:0]  xy_ff, xy_in;
   logic [DATA_BITS-1:0]  diff_ff, diff_in;
   logic [DATA_BITS-1:0]  nx_ff, nx_in;
   logic [DATA_BITS-1:0]  dbl_ff, dbl_in;
   logic                  neg_ff, neg_in;
   logic [ITER_BITS-1:0]  out_iter_ff, out_iter_in;
   logic                  out_esc_ff, out_esc_in;
   logic [DATA_BITS-1:0]  out_re_ff, out_re_in;
   logic [DATA_BITS-1:0]  out_im_ff, out_im_in;

   logic [DATA_BITS-1:0]  abs_x;
   logic [DATA_BITS-1:0]  abs_y;
   logic [DATA_BITS-1:0]  mul_a;
   logic [DATA_BITS-1:0]  mul_b;
   logic                  mul_neg;
   logic                  mul_done;
   logic [PROD_BITS-1:0]  product;
   logic [DATA_BITS-1:0]  qres;

   mbe_mul u_mul (
      .clock   (clock),
      .reset   (reset),
      .start   (cmd.mul_start),
      .a       (mul_a),
      .b       (mul_b),
      .done    (mul_done),
      .product (product)
   );

   always_comb begin
      abs_x = z_re_ff[DATA_BITS-1] ? (DATA_BITS'(0) - z_re_ff) : z_re_ff;
      abs_y = z_im_ff[DATA_BITS-1] ? (DATA_BITS'(0) - z_im_ff) : z_im_ff;
      mul_neg = 1'b0;
      unique case (cmd.mul_sel)
         MSEL_MAP_X: begin
            mul_a = DATA_BITS'(px_ff);
            mul_b = DATA_BITS'(x_step_ff);
         end
         MSEL_MAP_Y: begin
            mul_a = DATA_BITS'(py_ff);
            mul_b = DATA_BITS'(y_step_ff);
         end
         MSEL_XX: begin
            mul_a = abs_x;
            mul_b = abs_x;
         end
         MSEL_YY: begin
            mul_a = abs_y;
            mul_b = abs_y;
         end
         MSEL_XY: begin
            mul_a   = abs_x;
            mul_b   = abs_y;
            mul_neg = z_re_ff[DATA_BITS-1] ^ z_im_ff[DATA_BITS-1];
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
      qres = qfix(product, neg_ff);
   end

   always_comb begin
      x_left_in   = x_left_ff;
      x_step_in   = x_step_ff;
      y_top_in    = y_top_ff;
      y_step_in   = y_step_ff;
      max_iter_in = max_iter_ff;
      if (csr_valid) begin
         unique case (csr_idx_type'(csr_index))
            CSR_X_LEFT:   x_left_in   = csr_data;
            CSR_X_STEP:   x_step_in   = csr_data[STEP_BITS-1:0];
            CSR_Y_TOP:    y_top_in    = csr_data;
            CSR_Y_STEP:   y_step_in   = csr_data[STEP_BITS-1:0];
            CSR_MAX_ITER: max_iter_in = csr_data[ITER_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   always_comb begin
      z_re_in     = z_re_ff;
      z_im_in     = z_im_ff;
      c_re_in     = c_re_ff;
      c_im_in     = c_im_ff;
      n_in        = n_ff;
      esc_in      = esc_ff;
      px_in       = px_ff;
      py_in       = py_ff;
      xx_in       = xx_ff;
      yy_in       = yy_ff;
      xy_in       = xy_ff;
      diff_in     = diff_ff;
      nx_in       = nx_ff;
      dbl_in      = dbl_ff;
      neg_in      = neg_ff;
      out_iter_in = out_iter_ff;
      out_esc_in  = out_esc_ff;
      out_re_in   = out_re_ff;
      out_im_in   = out_im_ff;

      if (cmd.clear) begin
         px_in   = pixel_x;
         py_in   = pixel_y;
         z_re_in = '0;
         z_im_in = '0;
         n_in    = '0;
         esc_in  = 1'b0;
      end
      if (cmd.mul_start) begin
         neg_in = mul_neg;
      end
      if (cmd.load_map_x) begin
         c_re_in = map_up(x_left_ff, product);
      end
      if (cmd.load_map_y) begin
         c_im_in = map_down(y_top_ff, product);
      end
      if (cmd.load_xx) begin
         xx_in = qres;
      end
      if (cmd.load_yy) begin
         yy_in = qres;
      end
      if (cmd.load_xy) begin
         xy_in = qres;
      end
      if (cmd.eval_bail) begin
         esc_in  = (xx_ff + yy_ff) >= BAILOUT_SQ;
         diff_in = sat_sub(xx_ff, yy_ff);
      end
      if (cmd.eval_nx) begin
         nx_in = sat_add(diff_ff, c_re_ff);
      end
      if (cmd.eval_dbl) begin
         dbl_in = sat_add(xy_ff, xy_ff);
      end
      if (cmd.update) begin
         z_re_in = nx_ff;
         z_im_in = sat_add(dbl_ff, c_im_ff);
         n_in    = n_ff + 1'b1;
      end
      if (cmd.out_load) begin
         out_iter_in = n_ff;
         out_esc_in  = esc_ff;
         out_re_in   = z_re_ff;
         out_im_in   = z_im_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         x_left_ff   <= '0;
         x_step_ff   <= '0;
         y_top_ff    <= '0;
         y_step_ff   <= '0;
         max_iter_ff <= MAX_ITER_RESET;
         z_re_ff     <= '0;
         z_im_ff     <= '0;
         c_re_ff     <= '0;
         c_im_ff     <= '0;
         n_ff        <= '0;
         esc_ff      <= 1'b0;
      end else begin
         x_left_ff   <= x_left_in;
         x_step_ff   <= x_step_in;
         y_top_ff    <= y_top_in;
         y_step_ff   <= y_step_in;
         max_iter_ff <= max_iter_in;
         z_re_ff     <= z_re_in;
         z_im_ff     <= z_im_in;
         c_re_ff     <= c_re_in;
         c_im_ff     <= c_im_in;
         n_ff        <= n_in;
         esc_ff      <= esc_in;
      end
   end

   always_ff @(posedge clock) begin
      px_ff       <= px_in;
      py_ff       <= py_in;
      xx_ff       <= xx_in;
      yy_ff       <= yy_in;
      xy_ff       <= xy_in;
      diff_ff     <= diff_in;
      nx_ff       <= nx_in;
      dbl_ff      <= dbl_in;
      neg_ff      <= neg_in;
      out_iter_ff <= out_iter_in;
      out_esc_ff  <= out_esc_in;
      out_re_ff   <= out_re_in;
      out_im_ff   <= out_im_in;
   end

   assign stat.mul_done  = mul_done;
   assign stat.limit_hit = n_ff >= max_iter_ff;
   assign stat.esc_hit   = esc_ff;

   assign csr_ready  = 1'b1;
   assign iter_count = out_iter_ff;
   assign escaped    = out_esc_ff;
   assign final_re   = $signed(out_re_ff);
   assign final_im   = $signed(out_im_ff);

endmodule

`default_nettype wire

[hdl/mandelbrot_escape_time.sv]
// Escape-time unit for one pixel at a time.
// A transaction on req_bus carries a pixel column and row. The unit maps it to
// the point c with the configured left edge, top edge and per-pixel steps, then
// iterates z = z*z + c from zero in signed Q11.52 until |z|^2 reaches 400 or
// the iteration limit is met. A transaction on rsp_bus returns the count, the
// escaped flag and the final z.
// All products go through one shared 32x32 multiplier, four partial products
// per 64-bit product. A result is loaded when the limit check ends the pixel
// and when the escape check ends it because the point escapes.
// One pixel is in flight at a time; req_bus is ready only while the unit idles.
// A finished result waits in the output register, so a new pixel is accepted
// while rsp_bus is stalled; that pixel then holds in its final state until the
// previous result is taken.
// csr_bus is always ready; registers must be written only while the unit is
// idle, which the block itself does not enforce. Synchronous reset empties
// the output register, returns the controller to idle and sets the frame
// registers, z, c, the count and the escaped flag to zero but the limit to 256.
`default_nettype none

module mandelbrot_escape_time import mbe_pkg::*; (
   input  wire logic clock,
   input  wire logic reset,
   mbe_req_if.sink   req_bus,
   mbe_rsp_if.source rsp_bus,
   mbe_csr_if.sink   csr_bus
);

   cmd_type  cmd;
   stat_type stat;

   mbe_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .stat      (stat),
      .cmd       (cmd)
   );

   mbe_dpath u_dpath (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .stat       (stat),
      .pixel_x    (req_bus.pixel_x),
      .pixel_y    (req_bus.pixel_y),
      .csr_valid  (csr_bus.valid),
      .csr_ready  (csr_bus.ready),
      .csr_index  (csr_bus.index),
      .csr_data   (csr_bus.data),
      .iter_count (rsp_bus.iter_count),
      .escaped    (rsp_bus.escaped),
      .final_re   (rsp_bus.final_re),
      .final_im   (rsp_bus.final_im)
   );

`ifndef SYNTH
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !req_bus.ready)
      else $error("Input was still ready in the cycle after a transaction.");

   a_load_into_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_bus.valid || rsp_bus.ready))
      else $error("Result loaded over one that was not yet taken.");

   a_valid_from_load: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_bus.valid) |-> $past(cmd.out_load))
      else $error("Result became valid without a load.");

   a_start_when_waiting: assert property (@(posedge clock) disable iff (reset)
      (cmd.load_xx || cmd.load_yy || cmd.load_xy) |-> stat.mul_done)
      else $error("Product taken before the multiplier finished.");
`endif

endmodule

`default_nettype wire

[verif/tb_mandelbrot_escape_time.sv]
`default_nettype none

module tb_mandelbrot_escape_time import mbe_pkg::*; ();

   timeunit 1ns;
   timeprecision 1ps;

   localparam logic [63:0] Q_MAX         = 64'h7FFF_FFFF_FFFF_FFFF;
   localparam logic [63:0] Q_MIN         = 64'h8000_0000_0000_0000;
   localparam logic [63:0] Q_ONE         = 64'h0010_0000_0000_0000;
   localparam logic [63:0] ESCAPE_MAG_SQ = 64'd400 << 52;
   localparam logic [63:0] ALL_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;

   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_LO = 3'd5;
   localparam logic [CSR_IDX_BITS-1:0] CSR_SPARE_HI = 3'd7;

   localparam int unsigned RANDOM_PIXELS   = 650;
   localparam int unsigned PRESSURE_CYCLES = 1500;
   localparam int unsigned SETTLE_CYCLES   = 200;

   typedef struct packed {
      logic [ITER_BITS-1:0] iter_count;
      logic                 escaped;
      logic [63:0]          final_re;
      logic [63:0]          final_im;
   } escape_result_type;

   typedef struct {
      logic [63:0]          x_left;
      logic [62:0]          x_step;
      logic [63:0]          y_top;
      logic [62:0]          y_step;
      logic [ITER_BITS-1:0] max_iter;
   } frame_regs_type;

   typedef struct {
      logic [CSR_IDX_BITS-1:0] index;
      logic [63:0]             data;
   } reg_write_type;

   typedef enum {ROW_REG, ROW_PIXEL} row_kind_type;

   typedef struct {
      row_kind_type            kind;
      logic [CSR_IDX_BITS-1:0] reg_index;
      logic [63:0]             reg_data;
      logic [PIXEL_BITS-1:0]   px;
      logic [PIXEL_BITS-1:0]   py;
      bit                      known;
      escape_result_type       want;
   } plan_row_type;

   typedef enum {FRAME_OVERVIEW, FRAME_RAW, FRAME_ZOOM, FRAME_FAR, FRAME_DEEP} frame_kind_type;

   logic clock;
   logic reset;

   mbe_req_if req_bus ();
   mbe_rsp_if rsp_bus ();
   mbe_csr_if csr_bus ();

   mandelbrot_escape_time DUT (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   frame_regs_type       frame_regs = '{64'd0, 63'd0, 64'd0, 63'd0, ITER_BITS'(256)};
   logic [63:0]          pt_c_re, pt_c_im;
   logic [ITER_BITS-1:0] pt_iters;

   escape_result_type pending_escapes[$];
   int unsigned       field_mismatches = 0;
   int unsigned       pixels_checked   = 0;
   int unsigned       escaped_seen     = 0;
   int unsigned       settings_used    = 0;
   int unsigned       stall_bursts     = 0;
   int unsigned       req_steady_left  = 0;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #200_000_000;
      $display("Mismatches found");
      $finish;
   end

   function automatic logic [63:0] sat_add(logic [63:0] a, logic [63:0] b);
      logic [63:0] r;
      r = a + b;
      if (((a ^ r) & (b ^ r)) >> 63)
         return a[63] ? Q_MIN : Q_MAX;
      return r;
   endfunction

   function automatic logic [63:0] sat_sub(logic [63:0] a, logic [63:0] b);
      logic [63:0] r;
      r = a - b;
      if (((a ^ b) & (a ^ r)) >> 63)
         return a[63] ? Q_MIN : Q_MAX;
      return r;
   endfunction

   function automatic logic [63:0] fx_mul(logic [63:0] a, logic [63:0] b);
      logic [63:0]  ma, mb, q;
      logic [127:0] p;
      logic         ovf;
      ma  = a[63] ? (64'd0 - a) : a;
      mb  = b[63] ? (64'd0 - b) : b;
      p   = 128'(ma) * 128'(mb);
      ovf = p[127:116] != 0;
      q   = p[115:52];
      if (a[63] == b[63])
         return (ovf || q[63]) ? Q_MAX : q;
      if (ovf || q > Q_MIN)
         return Q_MIN;
      return 64'd0 - q;
   endfunction

   function automatic logic [63:0] map_edge(logic [63:0] origin, logic [PIXEL_BITS-1:0] pix,
                                            logic [62:0] step, bit downward);
      logic [127:0] offset;
      logic [63:0]  biased;
      offset = 128'(pix) * 128'(step);
      biased = origin ^ Q_MIN;
      if (!downward) begin
         if (offset[127:64] != 0 || offset[63:0] > ~biased)
            return Q_MAX;
         return (biased + offset[63:0]) ^ Q_MIN;
      end
      if (offset[127:64] != 0 || offset[63:0] > biased)
         return Q_MIN;
      return (biased - offset[63:0]) ^ Q_MIN;
   endfunction

   function automatic escape_result_type predict_escape(logic [PIXEL_BITS-1:0] px,
                                                        logic [PIXEL_BITS-1:0] py);
      logic [63:0]       x, y, xx, yy, xy, nx;
      logic [64:0]       mag;
      int unsigned       n;
      logic              esc;
      escape_result_type res;
      x   = '0;
      y   = '0;
      n   = 0;
      esc = 1'b0;
      pt_c_re = map_edge(frame_regs.x_left, px, frame_regs.x_step, 1'b0);
      pt_c_im = map_edge(frame_regs.y_top, py, frame_regs.y_step, 1'b1);
      while (n < frame_regs.max_iter) begin
         xx  = fx_mul(x, x);
         yy  = fx_mul(y, y);
         mag = {1'b0, xx} + {1'b0, yy};
         if (mag > {1'b0, Q_MAX})
            mag = {1'b0, Q_MAX};
         if (mag[63:0] >= ESCAPE_MAG_SQ) begin
            esc = 1'b1;
            break;
         end
         nx = sat_add(sat_sub(xx, yy), pt_c_re);
         xy = fx_mul(x, y);
         y  = sat_add(sat_add(xy, xy), pt_c_im);
         x  = nx;
         n++;
      end
      pt_iters = ITER_BITS'(n);
      res = '{iter_count: pt_iters, escaped: esc, final_re: x, final_im: y};
      return res;
   endfunction

   function automatic void apply_reg(logic [CSR_IDX_BITS-1:0] index, logic [63:0] data);
      case (index)
         CSR_X_LEFT:   frame_regs.x_left   = data;
         CSR_X_STEP:   frame_regs.x_step   = data[62:0];
         CSR_Y_TOP:    frame_regs.y_top    = data;
         CSR_Y_STEP:   frame_regs.y_step   = data[62:0];
         CSR_MAX_ITER: frame_regs.max_iter = data[ITER_BITS-1:0];
         default: ;
      endcase
   endfunction

   function automatic int unsigned idle_gap();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 60)
         return 0;
      if (pick < 94)
         return $urandom_range(1, 3);
      return $urandom_range(12, 60);
   endfunction

   function automatic logic [63:0] q_between(real lo, real hi);
      real pick;
      pick = lo + (hi - lo) * ($urandom() / 4294967296.0);
      return 64'(longint'(pick * 4503599627370496.0)) ^ 64'($urandom_range(0, 255));
   endfunction

   function automatic plan_row_type reg_row(logic [CSR_IDX_BITS-1:0] index,
                                            logic [63:0] data);
      plan_row_type row;
      row = '{kind: ROW_REG, reg_index: index, reg_data: data, px: '0, py: '0,
              known: 1'b0, want: '0};
      return row;
   endfunction

   function automatic plan_row_type pixel_row(int px, int py);
      plan_row_type row;
      row = '{kind: ROW_PIXEL, reg_index: '0, reg_data: '0, px: PIXEL_BITS'(px),
              py: PIXEL_BITS'(py), known: 1'b0, want: '0};
      return row;
   endfunction

   function automatic plan_row_type known_row(int px, int py, int iters, bit esc,
                                              logic [63:0] re, logic [63:0] im);
      plan_row_type row;
      row = pixel_row(px, py);
      row.known = 1'b1;
      row.want  = '{iter_count: ITER_BITS'(iters), escaped: esc, final_re: re, final_im: im};
      return row;
   endfunction

   task automatic send_pixel(logic [PIXEL_BITS-1:0] px, logic [PIXEL_BITS-1:0] py,
                             bit known, escape_result_type want);
      int unsigned       gap;
      escape_result_type expected;
      if (req_steady_left != 0) begin
         req_steady_left--;
         gap = 0;
      end else begin
         if ($urandom_range(0, 39) == 0)
            req_steady_left = $urandom_range(20, 60);
         gap = idle_gap();
      end
      if (gap != 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_bus.valid   <= 1'b1;
      req_bus.pixel_x <= px;
      req_bus.pixel_y <= py;
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
      expected = predict_escape(px, py);
      if (known)
         expected = want;
      pending_escapes.push_back(expected);
   endtask

   task automatic wait_drained();
      req_bus.valid <= 1'b0;
      while (pending_escapes.size() != 0) @(posedge clock);
   endtask

   task automatic write_regs(reg_write_type writes[$]);
      foreach (writes[i]) begin
         csr_bus.valid <= 1'b1;
         csr_bus.index <= writes[i].index;
         csr_bus.data  <= writes[i].data;
         @(posedge clock);
         while (!csr_bus.ready) @(posedge clock);
         apply_reg(writes[i].index, writes[i].data);
      end
      csr_bus.valid <= 1'b0;
      settings_used++;
   endtask

   // The result port is held off long enough that a finished transaction waits in the
   // output register while the next pixel is accepted and completed behind it.
   initial begin : result_sink
      int unsigned       hold;
      int unsigned       steady;
      escape_result_type want;
      hold   = 0;
      steady = 0;
      rsp_bus.ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid && rsp_bus.ready) begin
            if (pending_escapes.size() == 0) begin
               $error("result transaction with no pixel outstanding");
               field_mismatches++;
            end else begin
               want = pending_escapes.pop_front();
               if (rsp_bus.iter_count !== want.iter_count) begin
                  $error("iter_count: expected %0d, actual %0d", want.iter_count,
                         rsp_bus.iter_count);
                  field_mismatches++;
               end
               if (rsp_bus.escaped !== want.escaped) begin
                  $error("escaped: expected %0b, actual %0b", want.escaped, rsp_bus.escaped);
                  field_mismatches++;
               end
               if (rsp_bus.final_re !== want.final_re) begin
                  $error("final_re: expected %h, actual %h", want.final_re, rsp_bus.final_re);
                  field_mismatches++;
               end
               if (rsp_bus.final_im !== want.final_im) begin
                  $error("final_im: expected %h, actual %h", want.final_im, rsp_bus.final_im);
                  field_mismatches++;
               end
               pixels_checked++;
               if (want.escaped)
                  escaped_seen++;
            end
            if (pixels_checked == 100 || pixels_checked == 300 || pixels_checked == 500) begin
               hold = PRESSURE_CYCLES;
               stall_bursts++;
            end
         end
         if (hold != 0) begin
            hold--;
            rsp_bus.ready <= 1'b0;
         end else if (steady != 0) begin
            steady--;
            rsp_bus.ready <= 1'b1;
         end else begin
            if ($urandom_range(0, 49) == 0)
               steady = $urandom_range(50, 200);
            hold = idle_gap();
            rsp_bus.ready <= (hold == 0);
            if (hold != 0)
               hold--;
         end
      end
   end

   initial begin : stimulus
      plan_row_type   directed[$];
      reg_write_type  writes[$];
      frame_kind_type kind;
      int unsigned    phase;
      int unsigned    count;
      int unsigned    directed_sent;
      int unsigned    random_sent;

      phase         = 0;
      directed_sent = 0;
      random_sent   = 0;
      reset           <= 1'b1;
      req_bus.valid   <= 1'b0;
      req_bus.pixel_x <= '0;
      req_bus.pixel_y <= '0;
      csr_bus.valid   <= 1'b0;
      csr_bus.index   <= '0;
      csr_bus.data    <= '0;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      directed.push_back(known_row(0, 0, 256, 1'b0, 64'd0, 64'd0));
      directed.push_back(known_row(4095, 4095, 256, 1'b0, 64'd0, 64'd0));
      directed.push_back(reg_row(CSR_MAX_ITER, 64'd0));
      directed.push_back(known_row(4095, 0, 0, 1'b0, 64'd0, 64'd0));
      directed.push_back(reg_row(CSR_X_LEFT, Q_ONE));
      directed.push_back(reg_row(CSR_MAX_ITER, 64'h1_0000));
      directed.push_back(known_row(0, 4095, 0, 1'b0, 64'd0, 64'd0));
      directed.push_back(reg_row(CSR_X_LEFT, Q_MAX));
      directed.push_back(reg_row(CSR_X_STEP, ALL_ONES));
      directed.push_back(reg_row(CSR_Y_TOP, Q_MIN));
      directed.push_back(reg_row(CSR_Y_STEP, ALL_ONES));
      directed.push_back(reg_row(CSR_MAX_ITER, 64'd1));
      directed.push_back(known_row(0, 0, 1, 1'b0, Q_MAX, Q_MIN));
      directed.push_back(known_row(4095, 4095, 1, 1'b0, Q_MAX, Q_MIN));
      directed.push_back(reg_row(CSR_MAX_ITER, 64'd2));
      directed.push_back(known_row(4095, 4095, 1, 1'b1, Q_MAX, Q_MIN));
      directed.push_back(known_row(0, 0, 1, 1'b1, Q_MAX, Q_MIN));
      directed.push_back(reg_row(CSR_X_LEFT, Q_MIN));
      directed.push_back(reg_row(CSR_X_STEP, 64'd0));
      directed.push_back(reg_row(CSR_Y_TOP, Q_MAX));
      directed.push_back(reg_row(CSR_Y_STEP, 64'd0));
      directed.push_back(reg_row(CSR_MAX_ITER, 64'd65535));
      directed.push_back(known_row(2048, 2048, 1, 1'b1, Q_MIN, Q_MAX));
      directed.push_back(known_row(4095, 0, 1, 1'b1, Q_MIN, Q_MAX));
      directed.push_back(reg_row(CSR_X_LEFT, 64'd0 - (Q_ONE << 1)));
      directed.push_back(reg_row(CSR_X_STEP, 64'd3 << 40));
      directed.push_back(reg_row(CSR_Y_TOP, 64'd3 << 51));
      directed.push_back(reg_row(CSR_Y_STEP, 64'd3 << 40));
      directed.push_back(reg_row(CSR_MAX_ITER, 64'd32));
      for (int idx = CSR_SPARE_LO; idx <= CSR_SPARE_HI; idx++)
         directed.push_back(reg_row(CSR_IDX_BITS'(idx), ALL_ONES));
      directed.push_back(pixel_row(0, 0));
      directed.push_back(pixel_row(2048, 2048));
      directed.push_back(pixel_row(1365, 2048));
      directed.push_back(pixel_row(2731, 2048));
      directed.push_back(pixel_row(0, 2048));
      directed.push_back(pixel_row(4095, 4095));
      directed.push_back(pixel_row(3000, 1000));
      directed.push_back(pixel_row(2500, 1500));

      foreach (directed[i]) begin
         if (directed[i].kind == ROW_REG) begin
            writes.push_back('{directed[i].reg_index, directed[i].reg_data});
         end else begin
            if (writes.size() != 0) begin
               wait_drained();
               write_regs(writes);
               writes.delete();
            end
            send_pixel(directed[i].px, directed[i].py, directed[i].known, directed[i].want);
            directed_sent++;
         end
      end

      while (random_sent < RANDOM_PIXELS) begin
         writes.delete();
         case (phase % 7)
            0, 4:    kind = FRAME_OVERVIEW;
            1:       kind = FRAME_RAW;
            2, 6:    kind = FRAME_ZOOM;
            3:       kind = FRAME_FAR;
            default: kind = FRAME_DEEP;
         endcase
         case (kind)
            FRAME_OVERVIEW, FRAME_DEEP: begin
               writes.push_back('{CSR_X_LEFT, q_between(-2.6, -1.8)});
               writes.push_back('{CSR_X_STEP, q_between(2.4, 3.2) >> 12});
               writes.push_back('{CSR_Y_TOP, q_between(1.0, 1.6)});
               writes.push_back('{CSR_Y_STEP, q_between(2.0, 3.2) >> 12});
               writes.push_back('{CSR_MAX_ITER, (kind == FRAME_DEEP) ? 64'd256
                                                 : 64'($urandom_range(1, 24))});
            end
            FRAME_ZOOM: begin
               writes.push_back('{CSR_X_LEFT, q_between(-0.8, -0.7)});
               writes.push_back('{CSR_X_STEP, q_between(0.02, 0.2) >> 12});
               writes.push_back('{CSR_Y_TOP, q_between(0.1, 0.2)});
               writes.push_back('{CSR_Y_STEP, q_between(0.02, 0.2) >> 12});
               writes.push_back('{CSR_MAX_ITER, 64'($urandom_range(16, 48))});
            end
            FRAME_RAW: begin
               writes.push_back('{CSR_X_LEFT, {$urandom(), $urandom()}});
               writes.push_back('{CSR_X_STEP, {$urandom(), $urandom()}});
               writes.push_back('{CSR_Y_TOP, {$urandom(), $urandom()}});
               writes.push_back('{CSR_Y_STEP, {$urandom(), $urandom()}});
               writes.push_back('{CSR_MAX_ITER, {$urandom(), 16'($urandom()),
                                                 16'($urandom_range(1, 12))}});
            end
            default: begin
               writes.push_back('{CSR_X_LEFT, q_between(20.0, 900.0)});
               writes.push_back('{CSR_X_STEP, {$urandom(), $urandom()}});
               writes.push_back('{CSR_Y_TOP, {$urandom(), $urandom()}});
               writes.push_back('{CSR_Y_STEP, {$urandom(), $urandom()}});
               writes.push_back('{CSR_MAX_ITER, $urandom_range(0, 1) ? 64'd65535
                                                 : 64'($urandom_range(1000, 65534))});
            end
         endcase
         count = (kind == FRAME_DEEP) ? 12 : $urandom_range(30, 60);
         if (count > RANDOM_PIXELS - random_sent)
            count = RANDOM_PIXELS - random_sent;
         wait_drained();
         write_regs(writes);
         repeat (count)
            send_pixel(PIXEL_BITS'($urandom_range(0, 4095)),
                       PIXEL_BITS'($urandom_range(0, 4095)), 1'b0, '0);
         random_sent += count;
         phase++;
      end

      wait_drained();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("Checked %0d pixel results (%0d directed, %0d random) over %0d register settings.",
               pixels_checked, directed_sent, random_sent, settings_used);
      $display("%0d pixels escaped, %0d hit the limit; %0d long result-port stalls applied.",
               escaped_seen, pixels_checked - escaped_seen, stall_bursts);
      if (field_mismatches == 0)
         $display("No mismatches found");
      else
         $display("Mismatches found");
      $finish;
   end

endmodule

`default_nettype wire

[files.f]
hdl/mbe_pkg.sv
hdl/mbe_ifs.sv
hdl/mbe_mul.sv
hdl/mbe_ctrl.sv
hdl/mbe_dpath.sv
hdl/mandelbrot_escape_time.sv
verif/tb_mandelbrot_escape_time.sv
